// ===== rtl/btbgs_pkg.sv =====
// Shared types and constants for the gshare/bimodal branch predictor with BTB.
// No dependencies; imported by btbgs_ram users and the top level.
`timescale 1ns / 1ps
package btbgs_pkg;

	localparam int ADDR_W     = 64;
	localparam int CTR_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int HLEN_W     = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PRED_MODE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN = 1'd1;

	// predictor modes
	localparam logic MODE_BIMODAL = 1'b0;
	localparam logic MODE_GSHARE  = 1'b1;

	localparam logic [HLEN_W-1:0] HLEN_RESET = 5'd8;

	// 2-bit direction counter codes
	localparam logic [CTR_W-1:0] CTR_SNT = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WNT = 2'd1;
	localparam logic [CTR_W-1:0] CTR_WT  = 2'd2;
	localparam logic [CTR_W-1:0] CTR_ST  = 2'd3;

	localparam logic [ADDR_W-1:0] FALL_STEP = 64'd4;

	typedef struct packed {
		logic [ADDR_W-1:0] pc_address;
		logic [ADDR_W-1:0] actual_next_address;
	} btbgs_in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] predicted_next_address;
		logic              weak_state_miss;
	} btbgs_out_t;

	// one table row: direction counter and branch target
	typedef struct packed {
		logic [CTR_W-1:0]  ctr;
		logic [ADDR_W-1:0] target;
	} btbgs_entry_t;

endpackage

// ===== rtl/btbgs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module btbgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/btb_gshare_branch_predictor_unit.sv =====
// Top level: gshare/bimodal direction predictor with branch target buffer.
// Depends on btbgs_pkg and btbgs_ram.
//
//   port group          dir  handshake          beat contents
//   in_valid/in_data    in   in_stall (driven)  btbgs_in_t: pc, actual next address
//   out_valid/out_data  out  out_stall (input)  btbgs_out_t: prediction, weak miss
//   wr_en/wr_index      in   none               wr_data: register value
//
// One beat per cycle while the output is not stalled and no clearing pass runs; the table
// is read as a beat enters stage 1, then the counter/target update and result go to the output register.
// The table RAM has one read and one write port; a same-cycle read of the row
// being written is forwarded. After reset a clearing pass sets every counter to
// weakly not taken; in_stall is high during it.
// A stalled output holds its beat while the next one waits in stage 1.
`timescale 1ns / 1ps
module btb_gshare_branch_predictor_unit #(
	parameter int INDEX_BITS  = 10,
	parameter int HISTORY_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  btbgs_pkg::btbgs_in_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output btbgs_pkg::btbgs_out_t                out_data,
	input  logic                                 wr_en,
	input  logic [btbgs_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [btbgs_pkg::CFG_DATA_W-1:0]     wr_data
);

	import btbgs_pkg::*;

	localparam int DEPTH  = 1 << INDEX_BITS;
	localparam int XW     = (INDEX_BITS < HISTORY_MAX) ? INDEX_BITS : HISTORY_MAX;
	localparam int LEN_W  = 6;
	localparam int ENT_W  = $bits(btbgs_entry_t);

	// configuration and history
	logic                   mode_q;
	logic [HLEN_W-1:0]      hlen_q;
	logic [HISTORY_MAX-1:0] ghist_q;
	logic [HISTORY_MAX-1:0] hist_mask;
	logic [LEN_W-1:0]       len_eff;

	// clearing pass
	logic                  clr_busy_q;
	logic [INDEX_BITS-1:0] clr_idx_q;

	// stage 0
	logic                  in_acc;
	logic [INDEX_BITS-1:0] idx0;
	logic [INDEX_BITS-1:0] hist_ext;
	logic [ADDR_W-1:0]     fall0;
	logic                  taken0;

	// stage 1
	logic                  s1_vld;
	logic                  s1_adv;
	logic [INDEX_BITS-1:0] idx_s1;
	logic [ADDR_W-1:0]     fall_s1;
	logic [ADDR_W-1:0]     actual_s1;
	logic                  taken_s1;
	logic                  mode_s1;
	logic                  fwd_s1;
	btbgs_entry_t          fwd_data_s1;

	btbgs_entry_t          rd_ent;
	btbgs_entry_t          cur_ent;
	btbgs_entry_t          new_ent;
	logic [ADDR_W-1:0]     pred;
	logic                  miss;
	logic [ENT_W-1:0]      rdata;

	// output register
	logic                  out_vld_q;
	btbgs_out_t            out_q;

	// RAM write side
	logic                  ram_we;
	logic [INDEX_BITS-1:0] ram_waddr;
	btbgs_entry_t          ram_wdata;
	btbgs_entry_t          clr_ent;

	assign s1_adv   = s1_vld && (!out_vld_q || !out_stall);
	assign in_stall = clr_busy_q || (s1_vld && !s1_adv);
	assign in_acc   = in_valid && !in_stall;

	// effective history length, clamped to 1..HISTORY_MAX
	always_comb begin
		len_eff = {1'b0, hlen_q};
		if (len_eff == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_eff > LEN_W'(HISTORY_MAX)) begin
			len_eff = LEN_W'(HISTORY_MAX);
		end
		for (int i = 0; i < HISTORY_MAX; i++) begin
			hist_mask[i] = (LEN_W'(i) < len_eff);
		end
	end

	assign hist_ext = INDEX_BITS'(ghist_q[XW-1:0]);
	assign idx0     = (mode_q == MODE_GSHARE) ? (in_data.pc_address[3 +: INDEX_BITS] ^ hist_ext)
	                                          : in_data.pc_address[3 +: INDEX_BITS];
	assign fall0    = in_data.pc_address + FALL_STEP;
	assign taken0   = (in_data.actual_next_address != fall0);

	// configuration, history and clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_GSHARE;
			hlen_q     <= HLEN_RESET;
			ghist_q    <= '0;
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_PRED_MODE:   mode_q <= wr_data[0];
					REG_HISTORY_LEN: hlen_q <= wr_data[HLEN_W-1:0];
					default: ;
				endcase
			end
			if (in_acc && mode_q == MODE_GSHARE) begin
				ghist_q <= ((ghist_q << 1) | HISTORY_MAX'(taken0)) & hist_mask;
			end
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
				if (clr_idx_q == INDEX_BITS'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld <= 1'b0;
		end else if (in_acc) begin
			s1_vld <= 1'b1;
		end else if (s1_adv) begin
			s1_vld <= 1'b0;
		end
	end

	// stage 1 payload; forward the row written in the same cycle as the read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1      <= idx0;
			fall_s1     <= fall0;
			actual_s1   <= in_data.actual_next_address;
			taken_s1    <= taken0;
			mode_s1     <= mode_q;
			fwd_s1      <= s1_adv && (idx_s1 == idx0);
			fwd_data_s1 <= new_ent;
		end
	end

	assign rd_ent  = btbgs_entry_t'(rdata);
	assign cur_ent = fwd_s1 ? fwd_data_s1 : rd_ent;
	assign pred    = (cur_ent.ctr > CTR_WNT) ? cur_ent.target : fall_s1;
	assign miss    = (mode_s1 == MODE_GSHARE) && (actual_s1 != pred)
	                 && (cur_ent.ctr == CTR_WNT || cur_ent.ctr == CTR_WT);

	always_comb begin
		new_ent = cur_ent;
		if (taken_s1) begin
			new_ent.target = actual_s1;
			if (cur_ent.ctr != CTR_ST) begin
				new_ent.ctr = cur_ent.ctr + CTR_W'(1);
			end
		end else if (cur_ent.ctr != CTR_SNT) begin
			new_ent.ctr = cur_ent.ctr - CTR_W'(1);
		end
	end

	always_comb begin
		clr_ent.ctr    = CTR_WNT;
		clr_ent.target = '0;
	end

	assign ram_we    = clr_busy_q || s1_adv;
	assign ram_waddr = clr_busy_q ? clr_idx_q : idx_s1;
	assign ram_wdata = clr_busy_q ? clr_ent : new_ent;

	btbgs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ENT_W'(ram_wdata)),
		.re   (in_acc),
		.raddr(idx0),
		.rdata(rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.predicted_next_address <= pred;
			out_q.weak_state_miss        <= miss;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// checks
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !clr_busy_q)
		else $error("input beat accepted during clearing pass");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_busy_q |=> !clr_busy_q)
		else $error("clearing pass restarted");

	a_bimodal_no_miss: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld && mode_s1 == MODE_BIMODAL |-> !miss)
		else $error("weak miss flagged in bimodal mode");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld && !s1_adv |=> s1_vld && $stable(idx_s1))
		else $error("stage 1 beat lost while output stalled");

endmodule

// ===== tb/tb_btb_gshare_branch_predictor_unit.sv =====
// Testbench for btb_gshare_branch_predictor_unit: a shadow predictor checks every result beat.
// Depends on btbgs_pkg and the RTL of the unit; random stimulus, random sender gaps and receiver stalls.
`timescale 1ns / 1ps
module tb_btb_gshare_branch_predictor_unit;
	import btbgs_pkg::*;

	localparam int TBL_BITS    = 10;
	localparam int HIST_MAX    = 16;
	localparam int TABLE_DEPTH = 1 << TBL_BITS;
	localparam int SITES       = 12;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 110;

	// shadow copy of the counter table, target buffer and history
	class branch_shadow;
		logic [CTR_W-1:0]    ctr_tbl [TABLE_DEPTH];
		logic [ADDR_W-1:0]   tgt_tbl [TABLE_DEPTH];
		logic [HIST_MAX-1:0] ghist;
		logic                mode;
		logic [HLEN_W-1:0]   hlen;
		btbgs_out_t          pending_predictions [$];
		int                  errors;
		int                  beats_seen;

		function new();
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				ctr_tbl[i] = CTR_WNT;
				tgt_tbl[i] = '0;
			end
			ghist      = '0;
			mode       = MODE_GSHARE;
			hlen       = HLEN_RESET;
			errors     = 0;
			beats_seen = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
			if (idx == REG_PRED_MODE)
				mode = val[0];
			else if (idx == REG_HISTORY_LEN)
				hlen = val[HLEN_W-1:0];
		endfunction

		function int pending();
			return pending_predictions.size();
		endfunction

		function void absorb_branch(input btbgs_in_t b);
			logic [ADDR_W-1:0] fall;
			logic [ADDR_W-1:0] pred;
			logic [ADDR_W-1:0] wide;
			logic [TBL_BITS-1:0] row;
			logic [CTR_W-1:0] c;
			logic taken;
			int len;
			btbgs_out_t e;
			fall = b.pc_address + FALL_STEP;
			wide = b.pc_address >> 3;
			if (mode == MODE_GSHARE)
				wide = wide ^ {{(ADDR_W-HIST_MAX){1'b0}}, ghist};
			row  = wide[TBL_BITS-1:0];
			c    = ctr_tbl[row];
			pred = (c > CTR_WNT) ? tgt_tbl[row] : fall;
			e.predicted_next_address = pred;
			e.weak_state_miss = (mode == MODE_GSHARE) && (b.actual_next_address != pred) &&
				(c == CTR_WNT || c == CTR_WT);
			taken = (b.actual_next_address != fall);
			if (taken) begin
				if (c != CTR_ST)
					c = c + CTR_W'(1);
				tgt_tbl[row] = b.actual_next_address;
			end else begin
				if (c != CTR_SNT)
					c = c - CTR_W'(1);
			end
			ctr_tbl[row] = c;
			if (mode == MODE_GSHARE) begin
				// zero length acts as one, anything past the maximum as the maximum
				len = (hlen == 0) ? 1 : ((hlen > HIST_MAX) ? HIST_MAX : int'(hlen));
				ghist = {ghist[HIST_MAX-2:0], taken};
				for (int i = 0; i < HIST_MAX; i++)
					if (i >= len)
						ghist[i] = 1'b0;
			end
			pending_predictions.push_back(e);
		endfunction

		function void compare_prediction(input btbgs_out_t got);
			btbgs_out_t e;
			beats_seen++;
			if (pending_predictions.size() == 0) begin
				$error("result beat with nothing pending: predicted_next_address=%h weak_state_miss=%b",
					got.predicted_next_address, got.weak_state_miss);
				errors++;
				return;
			end
			e = pending_predictions.pop_front();
			if (got.predicted_next_address !== e.predicted_next_address) begin
				$error("predicted_next_address: expected %h, got %h",
					e.predicted_next_address, got.predicted_next_address);
				errors++;
			end
			if (got.weak_state_miss !== e.weak_state_miss) begin
				$error("weak_state_miss: expected %b, got %b", e.weak_state_miss, got.weak_state_miss);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	btbgs_in_t             in_data;
	logic                  out_valid;
	logic                  out_stall;
	btbgs_out_t            out_data;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	branch_shadow sb = new();

	logic phase_mode [PHASES] = '{MODE_GSHARE, MODE_GSHARE, MODE_BIMODAL, MODE_GSHARE,
		MODE_GSHARE, MODE_BIMODAL, MODE_GSHARE, MODE_GSHARE, MODE_GSHARE};
	int   phase_hlen [PHASES] = '{16, 1, 5, 31, 17, 16, 3, 12, 8};

	btb_gshare_branch_predictor_unit #(
		.INDEX_BITS (TBL_BITS),
		.HISTORY_MAX(HIST_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.compare_prediction(out_data);
	end

	function automatic int sender_gap();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic btbgs_in_t br(input logic [ADDR_W-1:0] pc, input logic [ADDR_W-1:0] act);
		btbgs_in_t b;
		b.pc_address          = pc;
		b.actual_next_address = act;
		return b;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic push_branch(input btbgs_in_t b);
		in_data  <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.absorb_branch(b);
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input logic mode, input logic [HLEN_W-1:0] hlen);
		logic [CFG_DATA_W-1:0] d;
		// upper bits are don't-care for the mode register
		d = {(CFG_DATA_W-1)'($urandom_range(0, 15)), mode};
		wr_en    <= 1'b1;
		wr_index <= REG_PRED_MODE;
		wr_data  <= d;
		sb.set_reg(REG_PRED_MODE, d);
		@(negedge clk);
		wr_index <= REG_HISTORY_LEN;
		wr_data  <= hlen;
		sb.set_reg(REG_HISTORY_LEN, hlen);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic run_directed();
		// reset settings: gshare, eight history bits; fall-through wrap at the top of memory
		push_branch(br(64'h0, 64'h4));
		push_branch(br('1, 64'h3));
		push_branch(br(64'hFFFF_FFFF_FFFF_FFFC, 64'h0));
		push_branch(br('1, '1));
		push_branch(br(64'h0, '1));
		push_branch(br(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555));
		push_branch(br(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
		wait_idle();
		// bimodal: walk one counter up to saturation and back down, miss flag stays low
		configure(MODE_BIMODAL, 5'd8);
		repeat (3) push_branch(br(64'h100, 64'h8000));
		push_branch(br(64'h100, 64'h9000));
		repeat (4) push_branch(br(64'h100, 64'h104));
		wait_idle();
		// zero history length behaves as one bit
		configure(MODE_GSHARE, 5'd0);
		repeat (4) push_branch(br(64'h200, 64'h300));
		push_branch(br(64'h200, 64'h204));
		push_branch(br(64'h200, 64'h300));
		wait_idle();
	endtask

	task automatic run_phase(input int count, input int gap_pct);
		logic [ADDR_W-1:0] site_pc  [SITES];
		logic [ADDR_W-1:0] site_tgt [SITES];
		int site_bias [SITES];
		btbgs_in_t b;
		int k;
		int r;
		for (k = 0; k < SITES; k++) begin
			site_pc[k]  = {$urandom, $urandom};
			site_tgt[k] = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: site_bias[k] = 95;
				1: site_bias[k] = 80;
				2: site_bias[k] = 50;
				default: site_bias[k] = 10;
			endcase
		end
		// last two sites alias the first one's table row
		for (k = SITES - 2; k < SITES; k++)
			site_pc[k] = site_pc[0] ^ (64'd1 << (TBL_BITS + 3 + k));
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				k = $urandom_range(0, SITES - 1);
				b.pc_address = site_pc[k];
				if ($urandom_range(0, 99) < site_bias[k]) begin
					if ($urandom_range(0, 9) == 0)
						site_tgt[k] = {$urandom, $urandom};
					b.actual_next_address = site_tgt[k];
				end else begin
					b.actual_next_address = site_pc[k] + FALL_STEP;
				end
			end else if (r < 88) begin
				b.pc_address          = {$urandom, $urandom};
				b.actual_next_address = b.pc_address + FALL_STEP;
			end else begin
				b.pc_address          = {$urandom, $urandom};
				b.actual_next_address = {$urandom, $urandom};
			end
			if ($urandom_range(0, 99) < gap_pct)
				pause_sender(sender_gap());
			push_branch(b);
		end
	endtask

	// receiver: random stall pattern, plus one long hold-off to back up the pipe
	initial begin
		bit held;
		int n;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.beats_seen >= 400) begin
				held = 1'b1;
				out_stall <= 1'b1;
				n = 300;
			end else begin
				n = $urandom_range(0, 99);
				if (n < 50) begin
					out_stall <= 1'b0;
					n = $urandom_range(1, 8);
				end else if (n < 85) begin
					out_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else if (n < 95) begin
					out_stall <= 1'b0;
					n = $urandom_range(20, 60);
				end else begin
					out_stall <= 1'b1;
					n = $urandom_range(10, 40);
				end
			end
			repeat (n - 1) @(negedge clk);
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		wr_en     = 1'b0;
		wr_index  = REG_PRED_MODE;
		wr_data   = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			configure(phase_mode[p], HLEN_W'(phase_hlen[p]));
			run_phase(PHASE_ITEMS, (p % 3) * 25);
			wait_idle();
		end
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
